// ===== rtl/core/okvt_pkg.sv =====
// Shared types, sizes and operation codes of the ordered key/value table.
package okvt_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W  = 5;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_WRITE  = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] key;
      logic [31:0] write_value;
   } req_payload_type;

   typedef struct packed {
      logic               found;
      logic [31:0]        read_value;
      logic [COUNT_W-1:0] entry_total;
      logic [1:0]         status;
   } rsp_payload_type;

   typedef struct packed {
      logic capture;
      logic compare;
      logic execute;
   } okvt_cmd_type;

endpackage

// ===== rtl/core/okvt_control.sv =====
// Sequencer that steps each transaction through capture, compare and execute.
module okvt_control
   import okvt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output okvt_cmd_type cmd
);

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_COMPARE = 2'd1;
   localparam logic [1:0] S_EXECUTE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_blocked;

   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.compare = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_COMPARE;
            end
         end
         S_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = S_EXECUTE;
         end
         S_EXECUTE: begin
            if (!out_blocked) begin
               cmd.execute = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/okvt_datapath.sv =====
// Entry cells with parallel key compare, update, append, clear and gap-closing shift.
module okvt_datapath
   import okvt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  okvt_cmd_type    cmd,
   input  req_payload_type req_payload,
   output rsp_payload_type rsp_payload
);

   logic [1:0]         op_ff;
   logic [31:0]        key_ff;
   logic [31:0]        value_ff;
   logic [CAPACITY-1:0] match_ff;
   logic [31:0]        keys_ff   [CAPACITY];
   logic [31:0]        values_ff [CAPACITY];
   logic [31:0]        keys_in   [CAPACITY];
   logic [31:0]        values_in [CAPACITY];
   logic [COUNT_W-1:0] count_ff, count_in;
   rsp_payload_type    rsp_ff, rsp_in;
   logic [IDX_W-1:0]   slot;
   logic               hit;
   logic [31:0]        hit_value;

   always_comb begin
      slot = '0;
      for (int j = CAPACITY - 1; j >= 0; j--) begin
         if (match_ff[j]) begin
            slot = IDX_W'(j);
         end
      end
   end

   assign hit       = |match_ff;
   assign hit_value = values_ff[slot];

   always_comb begin
      for (int j = 0; j < CAPACITY; j++) begin
         keys_in[j]   = keys_ff[j];
         values_in[j] = values_ff[j];
      end
      count_in           = count_ff;
      rsp_in.found       = hit;
      rsp_in.read_value  = hit ? hit_value : 32'd0;
      rsp_in.status      = ST_OK;
      unique case (op_ff)
         OP_WRITE: begin
            if (hit) begin
               values_in[slot] = value_ff;
            end else if (count_ff < COUNT_W'(CAPACITY)) begin
               keys_in[count_ff[IDX_W-1:0]]   = key_ff;
               values_in[count_ff[IDX_W-1:0]] = value_ff;
               count_in = count_ff + COUNT_W'(1);
            end else begin
               rsp_in.status = ST_FULL;
            end
         end
         OP_DELETE: begin
            if (hit) begin
               for (int j = 0; j < CAPACITY - 1; j++) begin
                  if (IDX_W'(j) >= slot) begin
                     keys_in[j]   = keys_ff[j+1];
                     values_in[j] = values_ff[j+1];
                  end
               end
               count_in = count_ff - COUNT_W'(1);
            end else begin
               rsp_in.status = ST_NOTFOUND;
            end
         end
         OP_CLEAR: begin
            count_in          = '0;
            rsp_in.found      = 1'b0;
            rsp_in.read_value = 32'd0;
         end
         default: begin
         end
      endcase
      rsp_in.entry_total = count_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_payload.operation;
         key_ff   <= req_payload.key;
         value_ff <= req_payload.write_value;
      end
      if (cmd.compare) begin
         for (int j = 0; j < CAPACITY; j++) begin
            match_ff[j] <= (COUNT_W'(j) < count_ff) && (keys_ff[j] == key_ff);
         end
      end
      if (cmd.execute) begin
         for (int j = 0; j < CAPACITY; j++) begin
            keys_ff[j]   <= keys_in[j];
            values_ff[j] <= values_in[j];
         end
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/core/ordered_key_value_table_unit.sv =====
// Top level of the ordered key/value table: sequencer, entry datapath and checks.
//
// A request transaction carries an operation (lookup, write, delete, clear),
// a key and a write value. Each request produces exactly one response
// transaction with found, the prior value, the entry count after the
// operation and a status code.
// Both channels use valid and stall; a transaction moves on a rising edge
// where valid is high and stall is low.
// A request passes through capture, a parallel compare of the key against
// all entry cells into a registered match vector, and an execute step that
// picks the first match, applies the update, append, shift or clear and
// loads the response register. The response valid is registered after the
// execute step, and no new request is taken until that step is done.
// The response register holds a finished result while the receiver stalls,
// and the next request is still taken and compared; its execute step waits
// until the pending response has been taken.
// Synchronous reset empties the table (entry count zero) and clears the
// response valid; entry contents are not cleared and need no sweep.
module ordered_key_value_table_unit
   import okvt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   okvt_cmd_type cmd;

   okvt_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   okvt_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("Request taken while a transaction was in progress.");

   a_response_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> ##3 rsp_valid)
      else $error("No response valid three edges after a request.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.entry_total <= COUNT_W'(CAPACITY)))
      else $error("Entry count exceeds capacity.");

   a_full_not_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.status != ST_OK)) |->
         (!rsp_payload.found && (rsp_payload.read_value == 32'd0)))
      else $error("Error status reported together with a hit.");

endmodule
